// ----- sv/duri_pkg.sv -----
// Shared types, character codes and decode functions for the data URI decoder.
// No dependencies.
package duri_pkg;

  // Character codes
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_B  = 8'h42;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_B  = 8'h62;
  localparam logic [7:0] CHAR_LC_E  = 8'h65;
  localparam logic [7:0] CHAR_LC_S  = 8'h73;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_4     = 8'h34;
  localparam logic [7:0] CHAR_6     = 8'h36;
  localparam logic [7:0] CHAR_9     = 8'h39;

  // Alphabet offsets
  localparam logic [5:0] SEXTET_LC_BASE  = 6'd26;
  localparam logic [5:0] SEXTET_DIG_BASE = 6'd52;
  localparam logic [5:0] SEXTET_PLUS     = 6'd62;
  localparam logic [5:0] SEXTET_SLASH    = 6'd63;

  // Keyword length ("base64")
  localparam logic [2:0] KW_LEN = 3'd6;

  // Result of one processed word
  typedef struct packed {
    logic       has_result;
    logic [7:0] data;
    logic       data_valid;
    logic       done;
    logic       no_comma_err;
  } step_res_t;

  // Base64 alphabet lookup: {valid, value}
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [7:0] d;
    d = 8'd0;
    if (ch >= CHAR_UC_A && ch <= CHAR_UC_Z) begin
      d = ch - CHAR_UC_A;
      return {1'b1, d[5:0]};
    end else if (ch >= CHAR_LC_A && ch <= CHAR_LC_Z) begin
      d = ch - CHAR_LC_A;
      return {1'b1, d[5:0] + SEXTET_LC_BASE};
    end else if (ch >= CHAR_0 && ch <= CHAR_9) begin
      d = ch - CHAR_0;
      return {1'b1, d[5:0] + SEXTET_DIG_BASE};
    end else if (ch == CHAR_PLUS) begin
      return {1'b1, SEXTET_PLUS};
    end else if (ch == CHAR_SLASH) begin
      return {1'b1, SEXTET_SLASH};
    end
    return 7'd0;
  endfunction

  // Does ch match keyword letter at position pos
  function automatic logic kw_letter(input logic [2:0] pos, input logic [7:0] ch);
    logic hit;
    hit = 1'b0;
    case (pos)
      3'd0:    hit = (ch == CHAR_LC_B) || (ch == CHAR_UC_B);
      3'd1:    hit = (ch == CHAR_LC_A);
      3'd2:    hit = (ch == CHAR_LC_S);
      3'd3:    hit = (ch == CHAR_LC_E);
      3'd4:    hit = (ch == CHAR_6);
      3'd5:    hit = (ch == CHAR_4);
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ----- sv/duri_core.sv -----
// Per-character decode step: header keyword search, raw pass-through and
// base64 bit packing, with the decoder state registers. Uses duri_pkg.
module duri_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,   // process the presented word this cycle
  input  logic [7:0]           char_i,
  input  logic                 last_i,
  output duri_pkg::step_res_t  res_o
);

  logic        after_comma_q, after_comma_d;
  logic        b64_mode_q, b64_mode_d;
  logic [2:0]  kw_prog_q, kw_prog_d;
  logic [11:0] acc_q, acc_d;
  logic [2:0]  held_q, held_d;

  logic [6:0]  sx;
  logic [2:0]  prog_next;
  logic [3:0]  nb;
  logic [3:0]  nb_rem;
  logic [11:0] shifted;

  // Next state and result for the presented character
  always_comb begin
    after_comma_d = after_comma_q;
    b64_mode_d    = b64_mode_q;
    kw_prog_d     = kw_prog_q;
    acc_d         = acc_q;
    held_d        = held_q;
    res_o         = '0;
    sx            = duri_pkg::sextet_of(char_i);
    prog_next     = 3'd0;
    nb            = {1'b0, held_q} + 4'd6;
    nb_rem        = nb - 4'd8;
    shifted       = 12'd0;

    if (!after_comma_q) begin
      if (char_i == duri_pkg::CHAR_COMMA) begin
        after_comma_d = 1'b1;
      end else if (!b64_mode_q) begin
        // keyword search with restart on the failing character
        if (duri_pkg::kw_letter(kw_prog_q, char_i)) begin
          prog_next = kw_prog_q + 3'd1;
        end else begin
          prog_next = duri_pkg::kw_letter(3'd0, char_i) ? 3'd1 : 3'd0;
        end
        if (prog_next == duri_pkg::KW_LEN) begin
          b64_mode_d = 1'b1;
          kw_prog_d  = 3'd0;
        end else begin
          kw_prog_d  = prog_next;
        end
      end
    end else if (!b64_mode_q) begin
      res_o.data_valid = 1'b1;
      res_o.data       = char_i;
    end else if (sx[6]) begin
      // pack the sextet, emit a byte once 8 bits are held
      acc_d = {acc_q[5:0], sx[5:0]};
      if (nb >= 4'd8) begin
        shifted          = acc_d >> nb_rem;
        res_o.data       = shifted[7:0];
        res_o.data_valid = 1'b1;
        held_d           = nb_rem[2:0];
      end else begin
        held_d = nb[2:0];
      end
    end

    res_o.done         = last_i;
    res_o.no_comma_err = last_i && !after_comma_d;
    res_o.has_result   = res_o.data_valid || last_i;

    // end of URI returns everything to reset
    if (last_i) begin
      after_comma_d = 1'b0;
      b64_mode_d    = 1'b0;
      kw_prog_d     = 3'd0;
      acc_d         = 12'd0;
      held_d        = 3'd0;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_comma_q <= 1'b0;
      b64_mode_q    <= 1'b0;
      kw_prog_q     <= 3'd0;
      acc_q         <= 12'd0;
      held_q        <= 3'd0;
    end else if (step_i) begin
      after_comma_q <= after_comma_d;
      b64_mode_q    <= b64_mode_d;
      kw_prog_q     <= kw_prog_d;
      acc_q         <= acc_d;
      held_q        <= held_d;
    end
  end

endmodule

// ----- sv/data_uri_base64_decoder.sv -----
// Data URI payload decoder: one character word in, at most one byte word out.
// Each word passes the input register, the decode step and the result register in order.
// Throughput: one word per cycle while the output is not stalled by m_axis_tready_i low.
// Words that produce no byte and are not last are absorbed with no output word.
// Reset (rst_ni low, asynchronous) clears both valid flags and all decoder state.
// Depends on duri_pkg and duri_core.
module data_uri_base64_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_in
  input  logic       s_axis_tlast_i,   // is_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] byte_out
  output logic [1:0] m_axis_tuser_o,   // [0] byte_valid, [1] no_comma_error
  output logic       m_axis_tlast_o    // done_res
);

  logic       in_vld_q;
  logic [7:0] in_char_q;
  logic       in_last_q;
  logic       out_vld_q;
  logic [7:0] out_data_q;
  logic [1:0] out_user_q;
  logic       out_last_q;

  logic                advance;
  logic                out_free;
  duri_pkg::step_res_t res;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign advance         = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Decode step and state
  duri_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .char_i (in_char_q),
    .last_i (in_last_q),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= advance && res.has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.has_result) begin
      out_data_q <= res.data;
      out_user_q <= {res.no_comma_err, res.data_valid};
      out_last_q <= res.done;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
